>>> rtl/hms_pkg.sv
package hms_pkg;

  // Default prescaler counter width
  localparam int PRESCALE_WIDTH_DEF = 16;

  // Configuration register
  localparam int          TPS_WIDTH = 16;
  localparam logic [15:0] TPS_RESET = 16'd60;

  // Display geometry
  localparam int          NUM_DIGITS = 6;
  localparam logic [2:0]  LAST_POS   = 3'(NUM_DIGITS - 1);

  // Edit positions, second ones first
  localparam logic [2:0] IDX_SEC_ONES  = 3'd0;
  localparam logic [2:0] IDX_SEC_TENS  = 3'd1;
  localparam logic [2:0] IDX_MIN_ONES  = 3'd2;
  localparam logic [2:0] IDX_MIN_TENS  = 3'd3;
  localparam logic [2:0] IDX_HOUR_ONES = 3'd4;
  localparam logic [2:0] IDX_HOUR_TENS = 3'd5;

  // All segments off (active low)
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  // Active-low seven-segment codes for 0..9
  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h40, 8'hF9, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'hF8, 8'h00, 8'h10
  };

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SELECT  = 2'd1,
    ACT_INC     = 2'd2,
    ACT_REFRESH = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } time_t;

  // Segment code of a digit; codes above nine fold back by ten
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [3:0] k;
    k = (d >= 4'd10) ? 4'(d - 4'd10) : d;
    return SEG_TABLE[k];
  endfunction

  // Digit of the time at an edit index
  function automatic logic [3:0] digit_at(input time_t t, input logic [2:0] idx);
    logic [3:0] d;
    unique case (idx)
      IDX_SEC_ONES:  d = t.second_ones;
      IDX_SEC_TENS:  d = 4'(t.second_tens);
      IDX_MIN_ONES:  d = t.minute_ones;
      IDX_MIN_TENS:  d = 4'(t.minute_tens);
      IDX_HOUR_ONES: d = t.hour_ones;
      IDX_HOUR_TENS: d = 4'(t.hour_tens);
      default:       d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/hms_if.sv
// Input channel: one action per transfer
interface hms_in_if;
  logic              valid;
  logic              ready;
  hms_pkg::action_t  action;
  logic              set_mode;

  modport source (output valid, action, set_mode, input ready);
  modport sink   (input valid, action, set_mode, output ready);
endinterface

// Result channel: time, display drive and edit position
interface hms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic [5:0] digit_enable;
  logic [7:0] segment_pattern;
  logic [2:0] selected_digit;

  modport source (output valid, hour_tens, hour_ones, minute_tens, minute_ones,
                  second_tens, second_ones, digit_enable, segment_pattern,
                  selected_digit, input ready);
  modport sink   (input valid, hour_tens, hour_ones, minute_tens, minute_ones,
                  second_tens, second_ones, digit_enable, segment_pattern,
                  selected_digit, output ready);
endinterface

// Configuration write channel: ticks per second
interface hms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ticks_per_second;

  modport source (output valid, ticks_per_second, input ready);
  modport sink   (input valid, ticks_per_second, output ready);
endinterface

>>> rtl/hms_time.sv
module hms_time #(
  parameter int PRESCALE_WIDTH = hms_pkg::PRESCALE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_data,
  input  logic                     step,
  input  hms_pkg::action_t         action,
  input  logic                     set_mode,
  output hms_pkg::time_t           time_nxt,
  output logic [2:0]               edit_pos_nxt,
  output logic [2:0]               edit_pos_q
);
  import hms_pkg::*;

  // Compare width covers both the counter and the register
  localparam int CW = ((PRESCALE_WIDTH > TPS_WIDTH) ? PRESCALE_WIDTH : TPS_WIDTH) + 1;

  logic [TPS_WIDTH-1:0]      tps_r;
  time_t                     time_r;
  logic [PRESCALE_WIDTH-1:0] sub_r, sub_nxt;
  logic [2:0]                edit_pos_r;
  logic [CW-1:0]             sub_inc;
  logic [CW-1:0]             tps_ext;

  // One second forward with BCD cascade and 24-hour wrap
  function automatic time_t advance(input time_t t);
    time_t r;
    r = t;
    if (t.second_ones < 4'd9) begin
      r.second_ones = t.second_ones + 4'd1;
    end else begin
      r.second_ones = 4'd0;
      if (t.second_tens < 3'd5) begin
        r.second_tens = t.second_tens + 3'd1;
      end else begin
        r.second_tens = 3'd0;
        if (t.minute_ones < 4'd9) begin
          r.minute_ones = t.minute_ones + 4'd1;
        end else begin
          r.minute_ones = 4'd0;
          if (t.minute_tens < 3'd5) begin
            r.minute_tens = t.minute_tens + 3'd1;
          end else begin
            r.minute_tens = 3'd0;
            if (t.hour_ones < 4'd9) begin
              r.hour_ones = t.hour_ones + 4'd1;
            end else begin
              r.hour_ones = 4'd0;
              r.hour_tens = t.hour_tens + 2'd1;
            end
            // 24 or more hours rolls over to midnight
            if (r.hour_tens == 2'd3 || (r.hour_tens == 2'd2 && r.hour_ones >= 4'd4)) begin
              r = '0;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Bump one digit, wrapping at its own limit
  function automatic time_t bump(input time_t t, input logic [2:0] idx);
    time_t r;
    r = t;
    unique case (idx)
      IDX_SEC_ONES:  r.second_ones = (t.second_ones >= 4'd9) ? 4'd0 : t.second_ones + 4'd1;
      IDX_SEC_TENS:  r.second_tens = (t.second_tens >= 3'd5) ? 3'd0 : t.second_tens + 3'd1;
      IDX_MIN_ONES:  r.minute_ones = (t.minute_ones >= 4'd9) ? 4'd0 : t.minute_ones + 4'd1;
      IDX_MIN_TENS:  r.minute_tens = (t.minute_tens >= 3'd5) ? 3'd0 : t.minute_tens + 3'd1;
      IDX_HOUR_ONES: r.hour_ones   = (t.hour_ones >= 4'd9) ? 4'd0 : t.hour_ones + 4'd1;
      IDX_HOUR_TENS: r.hour_tens   = (t.hour_tens >= 2'd2) ? 2'd0 : t.hour_tens + 2'd1;
      default:       r = t;
    endcase
    return r;
  endfunction

  assign sub_inc = CW'(sub_r) + CW'(1);
  assign tps_ext = CW'(tps_r);

  // Next state for the current action
  always_comb begin
    time_nxt     = time_r;
    sub_nxt      = sub_r;
    edit_pos_nxt = edit_pos_r;
    unique case (action)
      ACT_TICK: begin
        if (!set_mode) begin
          if (sub_inc >= tps_ext) begin
            sub_nxt  = '0;
            time_nxt = advance(time_r);
          end else begin
            sub_nxt = sub_inc[PRESCALE_WIDTH-1:0];
          end
        end
      end
      ACT_SELECT: begin
        if (set_mode) begin
          edit_pos_nxt = (edit_pos_r >= LAST_POS) ? 3'd0 : edit_pos_r + 3'd1;
        end
      end
      ACT_INC: begin
        if (set_mode) begin
          time_nxt = bump(time_r, edit_pos_r);
        end
      end
      ACT_REFRESH: begin
        time_nxt = time_r;
      end
      default: begin
        time_nxt = time_r;
      end
    endcase
  end

  // Time, prescaler, edit position and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r      <= TPS_RESET;
      time_r     <= '0;
      sub_r      <= '0;
      edit_pos_r <= 3'd0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_data;
      end
      if (step) begin
        time_r     <= time_nxt;
        sub_r      <= sub_nxt;
        edit_pos_r <= edit_pos_nxt;
      end
    end
  end

  assign edit_pos_q = edit_pos_r;

endmodule

>>> rtl/hms_disp.sv
module hms_disp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hms_pkg::action_t action,
  input  logic             set_mode,
  input  logic [2:0]       edit_pos,
  input  hms_pkg::time_t   time_cur,
  output logic [5:0]       digit_enable,
  output logic [7:0]       segment_pattern
);
  import hms_pkg::*;

  logic [2:0] scan_r, scan_nxt;

  // Pick the shown position and its digit
  always_comb begin
    logic [2:0] pos;
    logic [2:0] idx;
    pos             = 3'd0;
    idx             = 3'd0;
    scan_nxt        = scan_r;
    digit_enable    = '0;
    segment_pattern = SEG_BLANK;
    if (action == ACT_REFRESH) begin
      if (set_mode) begin
        idx = edit_pos;
        pos = LAST_POS - idx;
      end else begin
        pos      = scan_r;
        idx      = LAST_POS - pos;
        scan_nxt = (scan_r >= LAST_POS) ? 3'd0 : scan_r + 3'd1;
      end
      digit_enable    = 6'(6'd1 << pos);
      segment_pattern = seg_code(digit_at(time_cur, idx));
    end
  end

  // Scan position register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 3'd0;
    end else if (step) begin
      scan_r <= scan_nxt;
    end
  end

endmodule

>>> rtl/settable_hhmmss_clock_with_display_scan.sv
// Settable 24-hour HH:MM:SS clock with a six-digit seven-segment scan. Each
// input transfer carries one action (tick, select, increment, refresh) and
// yields exactly one result: the time after the action, the edit position,
// and for a refresh an active-low segment code with a one-hot digit enable
// (other actions give enable 0 and all segments off). One item is taken per
// clock unless a waiting result is not taken; the state update and display
// decode feed a single result register, valid in the cycle after accept; the
// input stays open while a result waits if the sink takes it in the same cycle.
// ticks_per_second is written through the cfg channel, which is always ready.
module settable_hhmmss_clock_with_display_scan #(
  parameter int PRESCALE_WIDTH = hms_pkg::PRESCALE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hms_in_if.sink    in_ch,
  hms_out_if.source out_ch,
  hms_cfg_if.sink   cfg_ch
);
  import hms_pkg::*;

  logic       accept;
  logic       out_valid_r;
  time_t      time_nxt;
  logic [2:0] edit_pos_nxt;
  logic [2:0] edit_pos_q;
  logic [5:0] enable_c;
  logic [7:0] pattern_c;
  time_t      time_out_r;
  logic [5:0] enable_out_r;
  logic [7:0] pattern_out_r;
  logic [2:0] sel_out_r;

  // Handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  hms_time #(
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_time (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_ch.valid),
    .cfg_data     (cfg_ch.ticks_per_second),
    .step         (accept),
    .action       (in_ch.action),
    .set_mode     (in_ch.set_mode),
    .time_nxt     (time_nxt),
    .edit_pos_nxt (edit_pos_nxt),
    .edit_pos_q   (edit_pos_q)
  );

  hms_disp u_disp (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .action          (in_ch.action),
    .set_mode        (in_ch.set_mode),
    .edit_pos        (edit_pos_nxt),
    .time_cur        (time_nxt),
    .digit_enable    (enable_c),
    .segment_pattern (pattern_c)
  );

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      time_out_r    <= time_nxt;
      enable_out_r  <= enable_c;
      pattern_out_r <= pattern_c;
      sel_out_r     <= edit_pos_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hour_tens       = time_out_r.hour_tens;
  assign out_ch.hour_ones       = time_out_r.hour_ones;
  assign out_ch.minute_tens     = time_out_r.minute_tens;
  assign out_ch.minute_ones     = time_out_r.minute_ones;
  assign out_ch.second_tens     = time_out_r.second_tens;
  assign out_ch.second_ones     = time_out_r.second_ones;
  assign out_ch.digit_enable    = enable_out_r;
  assign out_ch.segment_pattern = pattern_out_r;
  assign out_ch.selected_digit  = sel_out_r;

`ifndef SYNTH
  // At most one position is lit in any result
  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(enable_out_r))
    else $error("digit enable not one-hot");

  // No position enabled means all segments dark
  a_blank_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && enable_out_r == 6'd0) |-> pattern_out_r == SEG_BLANK)
    else $error("segments lit with no digit enabled");

  // Tens of minutes and seconds never pass five
  a_tens_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (time_out_r.minute_tens <= 3'd5 && time_out_r.second_tens <= 3'd5))
    else $error("tens digit out of range");

  // Edit position stays on the display
  a_edit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    edit_pos_q <= LAST_POS)
    else $error("edit position out of range");
`endif

endmodule
